>>> hw/rtl/wts_pkg.sv
// Shared types and constants for the windowed trend statistics block.
// Used by the front end, the job queue, the back end and the top level.
// Has no dependencies.
package wts_pkg;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned SMP_W = 24;
    localparam int unsigned SQ_W = 48;
    localparam int unsigned SUM_W = 41;
    localparam int unsigned SSQ_W = 63;
    localparam int unsigned OUT_W = 32;

    localparam logic [CNT_W-1:0] LEN_RESET = 17'd1024;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

    localparam int unsigned MEAN_SHIFT = 8;
    localparam int unsigned MS_SHIFT = 16;
    localparam int unsigned DVD_W = SSQ_W + MS_SHIFT;
    localparam int unsigned STEP_W = $clog2(DVD_W);
    localparam int unsigned RAD_W = 64;
    localparam int unsigned ROOT_W = RAD_W / 2;
    localparam int unsigned SQRT_STEPS = RAD_W / 2;
    localparam int unsigned REM_W = ROOT_W + 2;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SMP_W-1:0] minimum;
        logic signed [SMP_W-1:0] maximum;
        logic signed [SUM_W-1:0] sum;
        logic [SSQ_W-1:0]        sum_sq;
    } t_job;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } t_qstat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_SQRT,
        S_DONE
    } t_bstate;

endpackage

>>> hw/rtl/windowed_trend_statistics.sv
// Windowed trend statistics: count, minimum, maximum, mean and rms per window.
// The input channel takes one signed sample per word on i_in_valid/o_in_stall.
// i_cfg_we with i_cfg_wdata sets the window length; zero acts as one and values
// above MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
// After each window fills, one result word leaves on o_out_valid/i_out_stall
// with count, minimum, maximum, mean and rms; mean and rms carry 8 fractional
// bits, mean truncated toward zero and rms floored.
// Samples are taken one per cycle while o_in_stall is low. The closing sample's
// result is squared and accumulated, written to the queue, popped, run through
// 79 steps of the bit-serial dividers and 32 steps of the two-bit square root
// and then loaded into the output register. The back end takes one window at
// a time; a two-entry queue holds finished windows, and shorter windows stall
// the input once it is full.
// A stalled result stays in the output register while the back end works on
// the next window. Reset sets the window length to 1024 and empties the
// pipeline, the queue and the output register.
module windowed_trend_statistics #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned MAX_WINDOW = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wts_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [wts_pkg::SMP_W-1:0] i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [wts_pkg::CNT_W-1:0]        o_count,
    output logic signed [wts_pkg::SMP_W-1:0] o_minimum,
    output logic signed [wts_pkg::SMP_W-1:0] o_maximum,
    output logic signed [wts_pkg::OUT_W-1:0] o_mean_value,
    output logic [wts_pkg::OUT_W-1:0]        o_rms_value
);
    import wts_pkg::*;

    t_job   push_job;
    t_job   head_job;
    t_qstat qstat;
    logic   push;
    logic   pop;

    wts_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    wts_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_qstat(qstat)
    );

    wts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_count     (o_count),
        .o_minimum   (o_minimum),
        .o_maximum   (o_maximum),
        .o_mean_value(o_mean_value),
        .o_rms_value (o_rms_value)
    );

endmodule

>>> hw/rtl/wts_front.sv
// Front end: holds the window length register, accepts samples, squares them
// and accumulates count, minimum, maximum, sum and sum of squares per window.
// Depends on wts_pkg; pushes finished windows into wts_queue.
module wts_front #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned MAX_WINDOW = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wts_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wts_pkg::SMP_W-1:0]   i_sample,
    input  wts_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output wts_pkg::t_job               o_job
);
    import wts_pkg::*;

    logic [CNT_W-1:0]        r_len;
    logic [CNT_W-1:0]        r_count;
    logic                    r_v;
    logic                    r_first;
    logic                    r_last;
    logic [CNT_W-1:0]        r_n;
    logic signed [SMP_W-1:0] r_s;
    logic [SQ_W-1:0]         r_sq;
    logic signed [SMP_W-1:0] r_min;
    logic signed [SMP_W-1:0] r_max;
    logic signed [SUM_W-1:0] r_sum;
    logic [SSQ_W-1:0]        r_ssq;

    logic                    accept;
    logic signed [SMP_W-1:0] s_ext;
    logic [SMP_W-1:0]        mag;
    logic [SQ_W-1:0]         sq;
    logic [CNT_W-1:0]        len_eff;
    logic [CNT_W-1:0]        cnt_next;
    logic                    is_last;
    logic signed [SMP_W-1:0] n_min;
    logic signed [SMP_W-1:0] n_max;
    logic signed [SUM_W-1:0] n_sum;
    logic [SSQ_W-1:0]        n_ssq;
    logic [QLVL_W:0]         pending;

    assign s_ext = SMP_W'($signed(i_sample[SAMPLE_BITS-1:0]));
    assign mag = s_ext[SMP_W-1] ? SMP_W'(-s_ext) : SMP_W'(s_ext);
    assign sq = SQ_W'(mag) * SQ_W'(mag);

    always_comb begin
        priority if (r_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (r_len > CNT_W'(MAX_WINDOW)) begin
            len_eff = CNT_W'(MAX_WINDOW);
        end else begin
            len_eff = r_len;
        end
    end

    assign cnt_next = r_count + CNT_W'(1);
    assign is_last = (cnt_next >= len_eff);

    assign o_push = r_v && r_last;
    assign pending = {1'b0, i_qstat.level} + (QLVL_W + 1)'(o_push);
    assign o_in_stall = (pending >= (QLVL_W + 1)'(QDEPTH));
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_first) begin
            n_min = r_s;
            n_max = r_s;
            n_sum = SUM_W'(r_s);
            n_ssq = SSQ_W'(r_sq);
        end else begin
            n_min = (r_s < r_min) ? r_s : r_min;
            n_max = (r_s > r_max) ? r_s : r_max;
            n_sum = r_sum + SUM_W'(r_s);
            n_ssq = r_ssq + SSQ_W'(r_sq);
        end
    end

    assign o_job.count = r_n;
    assign o_job.minimum = n_min;
    assign o_job.maximum = n_max;
    assign o_job.sum = n_sum;
    assign o_job.sum_sq = n_ssq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
            r_count <= '0;
            r_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_v <= accept;
            if (accept) begin
                r_count <= is_last ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s <= s_ext;
            r_sq <= sq;
            r_first <= (r_count == '0);
            r_last <= is_last;
            r_n <= cnt_next;
        end
        if (r_v) begin
            r_min <= n_min;
            r_max <= n_max;
            r_sum <= n_sum;
            r_ssq <= n_ssq;
        end
    end

endmodule

>>> hw/rtl/wts_queue.sv
// Short queue of finished windows between the front end and the back end.
// Depends on wts_pkg for the job type and the queue depth.
module wts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wts_pkg::t_job   i_job,
    input  logic            i_pop,
    output wts_pkg::t_job   o_job,
    output wts_pkg::t_qstat o_qstat
);
    import wts_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    assign o_job = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_level == '0);
    assign o_qstat.full = (r_level == QLVL_W'(QDEPTH));
    assign o_qstat.level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            r_level <= r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= QLVL_W'(QDEPTH))
        else $error("Queue level exceeds its depth.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full |-> !i_push)
        else $error("Word pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.empty |-> !i_pop)
        else $error("Word popped from an empty queue.");

endmodule

>>> hw/rtl/wts_back.sv
// Back end: takes one finished window from the queue, divides the scaled sum
// and sum of squares by the count one bit a cycle, then takes the square root
// two bits a cycle and holds the result in an output register. Uses wts_pkg.
module wts_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wts_pkg::t_job                    i_job,
    input  wts_pkg::t_qstat                  i_qstat,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [wts_pkg::CNT_W-1:0]        o_count,
    output logic signed [wts_pkg::SMP_W-1:0] o_minimum,
    output logic signed [wts_pkg::SMP_W-1:0] o_maximum,
    output logic signed [wts_pkg::OUT_W-1:0] o_mean_value,
    output logic [wts_pkg::OUT_W-1:0]        o_rms_value
);
    import wts_pkg::*;

    t_bstate                 r_state;
    t_bstate                 n_state;
    logic [STEP_W-1:0]       r_step;
    logic [CNT_W-1:0]        r_n;
    logic signed [SMP_W-1:0] r_min;
    logic signed [SMP_W-1:0] r_max;
    logic                    r_neg;
    logic [DVD_W-1:0]        r_mdvd;
    logic [DVD_W-1:0]        r_sdvd;
    logic [CNT_W-1:0]        r_mrem;
    logic [CNT_W-1:0]        r_srem;
    logic [RAD_W-1:0]        r_rad;
    logic [ROOT_W-1:0]       r_root;
    logic [REM_W-1:0]        r_rem;
    logic                    r_out_valid;

    logic                    out_free;
    logic                    load_out;
    logic                    div_last;
    logic                    sqrt_last;
    logic [SUM_W-1:0]        sum_mag;
    logic [CNT_W:0]          m_sh;
    logic [CNT_W:0]          s_sh;
    logic                    m_ge;
    logic                    s_ge;
    logic [DVD_W-1:0]        s_quot;
    logic [REM_W+1:0]        r_sh;
    logic [REM_W+1:0]        trial;
    logic                    r_ge;
    logic [OUT_W-1:0]        mean_mag;

    assign out_free = !r_out_valid || !i_out_stall;
    assign div_last = (r_step == STEP_W'(DVD_W - 1));
    assign sqrt_last = (r_step == STEP_W'(SQRT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (div_last) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = !i_qstat.empty;
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign sum_mag = i_job.sum[SUM_W-1] ? SUM_W'(-i_job.sum) : SUM_W'(i_job.sum);

    assign m_sh = {r_mrem, r_mdvd[DVD_W-1]};
    assign s_sh = {r_srem, r_sdvd[DVD_W-1]};
    assign m_ge = (m_sh >= {1'b0, r_n});
    assign s_ge = (s_sh >= {1'b0, r_n});
    assign s_quot = {r_sdvd[DVD_W-2:0], s_ge};

    assign r_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign r_ge = (r_sh >= trial);

    assign mean_mag = r_mdvd[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_step <= '0;
            end else if (r_state == S_DIVIDE || r_state == S_SQRT) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_n <= i_job.count;
            r_min <= i_job.minimum;
            r_max <= i_job.maximum;
            r_neg <= i_job.sum[SUM_W-1];
            r_mdvd <= DVD_W'({sum_mag, MEAN_SHIFT'(0)});
            r_sdvd <= {i_job.sum_sq, MS_SHIFT'(0)};
            r_mrem <= '0;
            r_srem <= '0;
        end
        if (r_state == S_DIVIDE) begin
            r_mdvd <= {r_mdvd[DVD_W-2:0], m_ge};
            r_sdvd <= s_quot;
            r_mrem <= CNT_W'(m_ge ? m_sh - {1'b0, r_n} : m_sh);
            r_srem <= CNT_W'(s_ge ? s_sh - {1'b0, r_n} : s_sh);
            if (div_last) begin
                r_rad <= s_quot[RAD_W-1:0];
                r_root <= '0;
                r_rem <= '0;
            end
        end
        if (r_state == S_SQRT) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], r_ge};
            r_rem <= REM_W'(r_ge ? r_sh - trial : r_sh);
        end
        if (load_out) begin
            o_count <= r_n;
            o_minimum <= r_min;
            o_maximum <= r_max;
            o_mean_value <= r_neg ? $signed(-mean_mag) : $signed(mean_mag);
            o_rms_value <= r_root;
        end
    end

    assign o_out_valid = r_out_valid;

    a_start_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_DIVIDE && r_step == '0))
        else $error("Divider did not start from step zero after a pop.");

    a_divide_to_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE && div_last) |=> (r_state == S_SQRT && r_step == '0))
        else $error("Square root did not follow the last divide step.");

    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_rms_value[OUT_W-1] == 1'b0 || o_rms_value == 32'h8000_0000))
        else $error("Root mean square result out of range.");

endmodule
